>>> rtl/windowed_uniform_histogram_defines.svh
// Assertion macros used by the histogram top level.
`ifndef WINDOWED_UNIFORM_HISTOGRAM_DEFINES_SVH
`define WINDOWED_UNIFORM_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, checked on the rising edge of i_clk outside reset.
`define WUH_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising edge of i_clk outside reset.
`define WUH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/wuh_pkg.sv
package wuh_pkg;

    localparam int MAX_BINS   = 64;
    localparam int BIN_W      = $clog2(MAX_BINS);
    localparam int NB_W       = BIN_W + 1;
    localparam int DATA_W     = 32;
    localparam int CFG_NB_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int WORK_DEPTH = 4;
    localparam int WORK_AW    = $clog2(WORK_DEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LOW  = 2'd0,
        CFG_WINDOW_HIGH = 2'd1,
        CFG_BIN_SCALE   = 2'd2,
        CFG_BINS_IN_USE = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic             count;
        logic             final_sample;
    } t_work;

    typedef struct packed {
        logic [BIN_W-1:0]  bin_number;
        logic [DATA_W-1:0] bin_count;
        logic              last_bin;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INC,
        S_OUT_RD,
        S_OUT_PUSH
    } t_back_state;

    function automatic logic [NB_W-1:0] f_active_bins(input logic [CFG_NB_W-1:0] n);
        logic [NB_W-1:0] r;
        if (n == '0) begin
            r = NB_W'(1);
        end else if (n > CFG_NB_W'(MAX_BINS)) begin
            r = NB_W'(MAX_BINS);
        end else begin
            r = n[NB_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/windowed_uniform_histogram.sv
// Windowed histogram of Q16.16 positions over up to 64 uniform bins.
// Samples enter through a queue-like port: a request is taken when push is
// high and full is low. Configuration is written through i_cfg_we, i_cfg_idx
// and i_cfg_data; the user must write it only while no sample or readout is
// in progress, as the block itself does not enforce this.
// A sample passes through the front pipeline (window check and difference,
// then the scale multiply) before it reaches a four-entry work queue. Samples
// that fall outside the window or past the bins in use and are not marked
// final leave the pipeline there and cost the back end nothing.
// For each counted sample the back end reads the counter RAM in S_IDLE and
// writes it back in S_INC before it takes the next sample from the work
// queue. Dropped samples are taken one per cycle while full is low.
// On a sample marked final, that sample is counted first if it is in the
// window and the bins in use, and then every bin in use is read out, in
// S_OUT_RD and S_OUT_PUSH for each bin, through a two-entry output buffer.
// Results are taken when pop is high and empty is low. When the receiver
// stalls, the readout pauses, the work queue fills and full rises.
// Reset restores the register defaults and marks all counters as zero at
// once; counters are cleared the same way after each readout.
`include "windowed_uniform_histogram_defines.svh"

module windowed_uniform_histogram import wuh_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [31:0]          i_position,
    input  logic                 i_final_sample,
    output logic                 empty,
    input  logic                 pop,
    output logic [BIN_W-1:0]     o_bin_number,
    output logic [DATA_W-1:0]    o_bin_count,
    output logic                 o_last_bin,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data
);

    logic [31:0]         r_window_low;
    logic [31:0]         r_window_high;
    logic [31:0]         r_bin_scale;
    logic [CFG_NB_W-1:0] r_bins_in_use;

    logic [NB_W-1:0]     w_nb;
    logic                w_q_push;
    logic                w_q_full;
    logic                w_q_pop;
    logic                w_q_empty;
    t_work               w_q_in;
    t_work               w_q_out;
    t_result             w_result;
    logic [NB_W-1:0]     w_bin_next;

    assign w_nb = f_active_bins(r_bins_in_use);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_low  <= 32'h0000_0000;
            r_window_high <= 32'h7FFF_FFFF;
            r_bin_scale   <= 32'h0001_0000;
            r_bins_in_use <= CFG_NB_W'(64);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WINDOW_LOW:  r_window_low  <= i_cfg_data;
                CFG_WINDOW_HIGH: r_window_high <= i_cfg_data;
                CFG_BIN_SCALE:   r_bin_scale   <= i_cfg_data;
                CFG_BINS_IN_USE: r_bins_in_use <= i_cfg_data[CFG_NB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    wuh_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_position     (i_position),
        .i_final_sample (i_final_sample),
        .i_window_low   (r_window_low),
        .i_window_high  (r_window_high),
        .i_bin_scale    (r_bin_scale),
        .i_nb           (w_nb),
        .o_q_push       (w_q_push),
        .o_q_work       (w_q_in),
        .i_q_full       (w_q_full)
    );

    wuh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_out),
        .o_empty (w_q_empty)
    );

    wuh_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_q_data  (w_q_out),
        .o_q_pop   (w_q_pop),
        .i_nb      (w_nb),
        .o_result  (w_result),
        .o_empty   (empty),
        .i_pop     (pop)
    );

    assign o_bin_number = w_result.bin_number;
    assign o_bin_count  = w_result.bin_count;
    assign o_last_bin   = w_result.last_bin;

    assign w_bin_next = {1'b0, o_bin_number} + NB_W'(1);

    `WUH_ASSERT(a_last_is_top_bin, !empty && o_last_bin, w_bin_next == w_nb, "last bin not on top")
    `WUH_ASSERT(a_inner_bin_below_top, !empty && !o_last_bin, w_bin_next < w_nb, "bin out of range")
    `WUH_ASSERT_NEXT(a_bins_in_order, pop && !empty && !o_last_bin, empty || (o_bin_number == $past(o_bin_number) + 1'b1), "bins out of order")

endmodule

>>> rtl/wuh_ram.sv
module wuh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/wuh_front.sv
module wuh_front import wuh_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [31:0]       i_position,
    input  logic              i_final_sample,
    input  logic [31:0]       i_window_low,
    input  logic [31:0]       i_window_high,
    input  logic [31:0]       i_bin_scale,
    input  logic [NB_W-1:0]   i_nb,
    output logic              o_q_push,
    output t_work             o_q_work,
    input  logic              i_q_full
);

    logic              r_v1;
    logic [31:0]       r_diff1;
    logic              r_win1;
    logic              r_fin1;
    logic              r_v2;
    logic [63:0]       r_prod2;
    logic              r_win2;
    logic              r_fin2;

    logic [32:0]       w_diff;
    logic              w_in_window;
    logic [63:0]       w_prod;
    logic [31:0]       w_bin_hi;
    logic              w_count;
    logic              w_adv1;
    logic              w_adv2;
    logic              w_accept;

    assign w_diff      = {i_position[31], i_position} - {i_window_low[31], i_window_low};
    assign w_in_window = ($signed(i_position) >= $signed(i_window_low)) &&
                         ($signed(i_position) <= $signed(i_window_high));
    assign w_prod      = 64'(r_diff1) * 64'(i_bin_scale);

    assign w_bin_hi = r_prod2[63:32];
    assign w_count  = r_win2 && (w_bin_hi < 32'(i_nb));

    assign w_adv2   = !r_v2 || !i_q_full;
    assign w_adv1   = !r_v1 || w_adv2;
    assign w_accept = i_push && w_adv1;
    assign o_full   = !w_adv1;

    assign o_q_push              = r_v2 && !i_q_full && (w_count || r_fin2);
    assign o_q_work.bin          = w_bin_hi[BIN_W-1:0];
    assign o_q_work.count        = w_count;
    assign o_q_work.final_sample = r_fin2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= w_accept;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_diff1 <= w_diff[31:0];
            r_win1  <= w_in_window;
            r_fin1  <= i_final_sample;
        end
        if (w_adv2) begin
            r_prod2 <= w_prod;
            r_win2  <= r_win1;
            r_fin2  <= r_fin1;
        end
    end

endmodule

>>> rtl/wuh_queue.sv
module wuh_queue import wuh_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_work o_data,
    output logic  o_empty
);

    t_work              r_mem [WORK_DEPTH];
    logic [WORK_AW-1:0] r_wp;
    logic [WORK_AW-1:0] r_rp;
    logic [WORK_AW:0]   r_cnt;

    logic               w_do_push;
    logic               w_do_pop;

    assign o_full    = r_cnt == (WORK_AW + 1)'(WORK_DEPTH);
    assign o_empty   = r_cnt == '0;
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

>>> rtl/wuh_back.sv
module wuh_back import wuh_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  t_work           i_q_data,
    output logic            o_q_pop,
    input  logic [NB_W-1:0] i_nb,
    output t_result         o_result,
    output logic            o_empty,
    input  logic            i_pop
);

    t_back_state        r_state;
    t_back_state        n_state;
    t_work              r_work;
    t_work              n_work;
    logic [BIN_W-1:0]   r_addr;
    logic [BIN_W-1:0]   n_addr;
    logic [BIN_W-1:0]   r_k;
    logic [BIN_W-1:0]   n_k;
    logic [MAX_BINS-1:0] r_valid;

    t_result            r_ob [2];
    logic               r_ob_wp;
    logic               r_ob_rp;
    logic [1:0]         r_ob_cnt;

    logic [BIN_W-1:0]   w_raddr;
    logic [DATA_W-1:0]  w_rdata;
    logic [DATA_W-1:0]  w_old;
    logic [DATA_W-1:0]  w_inc;
    logic               w_we;
    logic               w_clear;
    logic               w_last;
    logic               w_ob_full;
    logic               w_ob_push;
    logic               w_ob_pop;
    t_result            w_ob_data;

    wuh_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_BINS)
    ) u_counters (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_addr),
        .i_wdata (w_inc),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_old     = r_valid[r_addr] ? w_rdata : '0;
    assign w_inc     = (&w_old) ? w_old : w_old + 1'b1;
    assign w_last    = ({1'b0, r_k} + NB_W'(1)) == i_nb;
    assign w_ob_full = r_ob_cnt == 2'd2;
    assign o_empty   = r_ob_cnt == 2'd0;
    assign w_ob_pop  = i_pop && !o_empty;
    assign o_result  = r_ob[r_ob_rp];

    assign w_ob_data.bin_number = r_addr;
    assign w_ob_data.bin_count  = w_old;
    assign w_ob_data.last_bin   = w_last;

    always_comb begin
        n_state   = r_state;
        n_work    = r_work;
        n_addr    = r_addr;
        n_k       = r_k;
        o_q_pop   = 1'b0;
        w_raddr   = r_addr;
        w_we      = 1'b0;
        w_clear   = 1'b0;
        w_ob_push = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_work  = i_q_data;
                    if (i_q_data.count) begin
                        w_raddr = i_q_data.bin;
                        n_addr  = i_q_data.bin;
                        n_state = S_INC;
                    end else if (i_q_data.final_sample) begin
                        n_k     = '0;
                        n_state = S_OUT_RD;
                    end
                end
            end
            S_INC: begin
                w_we = 1'b1;
                if (r_work.final_sample) begin
                    n_k     = '0;
                    n_state = S_OUT_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT_RD: begin
                if (!w_ob_full) begin
                    w_raddr = r_k;
                    n_addr  = r_k;
                    n_state = S_OUT_PUSH;
                end
            end
            S_OUT_PUSH: begin
                w_ob_push = 1'b1;
                if (w_last) begin
                    w_clear = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_OUT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_ob_wp  <= 1'b0;
            r_ob_rp  <= 1'b0;
            r_ob_cnt <= 2'd0;
        end else begin
            r_state <= n_state;
            if (w_clear) begin
                r_valid <= '0;
            end else if (w_we) begin
                r_valid[r_addr] <= 1'b1;
            end
            if (w_ob_push) begin
                r_ob_wp <= !r_ob_wp;
            end
            if (w_ob_pop) begin
                r_ob_rp <= !r_ob_rp;
            end
            if (w_ob_push && !w_ob_pop) begin
                r_ob_cnt <= r_ob_cnt + 1'b1;
            end else if (w_ob_pop && !w_ob_push) begin
                r_ob_cnt <= r_ob_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_addr <= n_addr;
        r_k    <= n_k;
        if (w_ob_push) begin
            r_ob[r_ob_wp] <= w_ob_data;
        end
    end

endmodule
